/* hdl/i2cmb_pkg.sv */
package i2cmb_pkg;

    // Queue depth between front and back, and of the result queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_BIT_LOW     = 3'd0;
    localparam logic [2:0] REG_BIT_HIGH    = 3'd1;
    localparam logic [2:0] REG_READ_HIGH   = 3'd2;
    localparam logic [2:0] REG_START_STOP  = 3'd3;
    localparam logic [2:0] REG_ACK_TIMEOUT = 3'd4;

    localparam logic [7:0] RST_BIT_LOW     = 8'd4;
    localparam logic [7:0] RST_BIT_HIGH    = 8'd2;
    localparam logic [7:0] RST_READ_HIGH   = 8'd4;
    localparam logic [7:0] RST_START_STOP  = 8'd4;
    localparam logic [7:0] RST_ACK_TIMEOUT = 8'd250;

    // Request codes on the req_type field
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } ctick_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } result_t;

    typedef struct packed {
        logic [7:0] bit_low_ticks;
        logic [7:0] bit_high_ticks;
        logic [7:0] read_high_ticks;
        logic [7:0] start_stop_ticks;
        logic [7:0] ack_timeout_ticks;
    } cfg_t;

    typedef enum logic [13:0] {
        PH_IDLE   = 14'h0001,
        PH_ST_HI  = 14'h0002,
        PH_ST_LO  = 14'h0004,
        PH_SP_LO  = 14'h0008,
        PH_SP_HI  = 14'h0010,
        PH_SP_REL = 14'h0020,
        PH_W_LOW  = 14'h0040,
        PH_W_HIGH = 14'h0080,
        PH_A_REL  = 14'h0100,
        PH_A_WAIT = 14'h0200,
        PH_R_LOW  = 14'h0400,
        PH_R_HIGH = 14'h0800,
        PH_K_LOW  = 14'h1000,
        PH_K_HIGH = 14'h2000
    } phase_t;

endpackage

/* hdl/i2cmb_front.sv */
module i2cmb_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  i2cmb_pkg::tick_t tick,
    output logic             q_valid,
    input  logic             q_pop,
    output i2cmb_pkg::ctick_t q_item
);

    i2cmb_pkg::ctick_t                  mem_reg [i2cmb_pkg::Q_DEPTH];
    logic [i2cmb_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [i2cmb_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [i2cmb_pkg::Q_CNT_W-1:0]      count_reg, count_next;
    logic                               push_ok;
    logic                               pop_ok;
    i2cmb_pkg::ctick_t                  classified;

    // Decode the command up front so the back end only sees a kind
    always_comb
    begin
        classified.tx_byte  = tick.tx_byte;
        classified.send_ack = tick.send_ack;
        classified.sda_in   = tick.sda_in;
        classified.kind     = i2cmb_pkg::CMD_NONE;
        if (tick.cmd_valid)
        begin
            case (tick.req_type)
                i2cmb_pkg::REQ_START: classified.kind = i2cmb_pkg::CMD_START;
                i2cmb_pkg::REQ_STOP:  classified.kind = i2cmb_pkg::CMD_STOP;
                i2cmb_pkg::REQ_WRITE: classified.kind = i2cmb_pkg::CMD_WRITE;
                i2cmb_pkg::REQ_READ:  classified.kind = i2cmb_pkg::CMD_READ;
                default:              classified.kind = i2cmb_pkg::CMD_NONE;
            endcase
        end
    end

    assign full    = (count_reg == i2cmb_pkg::Q_CNT_W'(i2cmb_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push_ok = push && !full;
    assign pop_ok  = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + i2cmb_pkg::Q_PTR_W'(push_ok);
        rd_ptr_next = rd_ptr_reg + i2cmb_pkg::Q_PTR_W'(pop_ok);
        count_next  = count_reg + i2cmb_pkg::Q_CNT_W'(push_ok)
                      - i2cmb_pkg::Q_CNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

    a_pop_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("back end popped an empty tick queue");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !q_pop) |=> full)
        else $error("tick queue lost a beat while full");

endmodule

/* hdl/i2cmb_back.sv */
module i2cmb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  i2cmb_pkg::cfg_t    cfg,
    input  logic               q_valid,
    output logic               q_pop,
    input  i2cmb_pkg::ctick_t  q_item,
    output logic               empty,
    input  logic               pop,
    output i2cmb_pkg::result_t result
);

    i2cmb_pkg::phase_t phase_reg, phase_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] ack_wait_count_reg, ack_wait_count_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg, scl_next;
    logic       sda_drive_reg, sda_drive_next;
    logic       sda_level_reg, sda_level_next;
    logic       error_flag_reg, error_flag_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    logic       done;
    logic       step;
    logic [7:0] seg_len;
    logic       seg_done;
    logic [3:0] bit_inc;
    logic [7:0] shift_left;

    i2cmb_pkg::result_t            res_mem_reg [i2cmb_pkg::Q_DEPTH];
    logic [i2cmb_pkg::Q_PTR_W-1:0] res_wr_reg, res_rd_reg;
    logic [i2cmb_pkg::Q_CNT_W-1:0] res_count_reg, res_count_next;
    logic                          res_pop_ok;
    i2cmb_pkg::result_t            res_item;

    assign step  = q_valid && (res_count_reg != i2cmb_pkg::Q_CNT_W'(i2cmb_pkg::Q_DEPTH));
    assign q_pop = step;

    // Length of the segment the current phase is timing
    always_comb
    begin
        case (phase_reg)
            i2cmb_pkg::PH_ST_HI,
            i2cmb_pkg::PH_ST_LO,
            i2cmb_pkg::PH_SP_LO,
            i2cmb_pkg::PH_SP_HI,
            i2cmb_pkg::PH_SP_REL: seg_len = cfg.start_stop_ticks;
            i2cmb_pkg::PH_W_LOW,
            i2cmb_pkg::PH_R_LOW:  seg_len = cfg.bit_low_ticks;
            i2cmb_pkg::PH_W_HIGH,
            i2cmb_pkg::PH_K_HIGH: seg_len = cfg.bit_high_ticks;
            i2cmb_pkg::PH_R_HIGH: seg_len = cfg.read_high_ticks;
            i2cmb_pkg::PH_K_LOW:  seg_len = ack_choice_reg ? 8'd1 : 8'd2;
            default:              seg_len = 8'd1;
        endcase
    end

    assign seg_done   = !(tick_count_reg < seg_len);
    assign bit_inc    = bit_index_reg + 4'd1;
    assign shift_left = {shift_reg[6:0], 1'b0};

    always_comb
    begin
        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        bit_index_next      = bit_index_reg;
        shift_next          = shift_reg;
        ack_wait_count_next = ack_wait_count_reg;
        ack_choice_next     = ack_choice_reg;
        scl_next            = scl_reg;
        sda_drive_next      = sda_drive_reg;
        sda_level_next      = sda_level_reg;
        error_flag_next     = error_flag_reg;
        rx_hold_next        = rx_hold_reg;
        done                = 1'b0;

        if (step)
        begin
            // Segment timer: count up until the length is reached
            if (!seg_done && phase_reg != i2cmb_pkg::PH_IDLE
                && phase_reg != i2cmb_pkg::PH_A_WAIT)
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end

            case (phase_reg)
                i2cmb_pkg::PH_IDLE:
                begin
                    case (q_item.kind)
                        i2cmb_pkg::CMD_START:
                        begin
                            phase_next      = i2cmb_pkg::PH_ST_HI;
                            scl_next        = 1'b1;
                            tick_count_next = 8'd1;
                            sda_level_next  = 1'b1;
                            sda_drive_next  = 1'b0;
                        end
                        i2cmb_pkg::CMD_STOP:
                        begin
                            phase_next      = i2cmb_pkg::PH_SP_LO;
                            scl_next        = 1'b0;
                            tick_count_next = 8'd1;
                            sda_level_next  = 1'b0;
                            sda_drive_next  = 1'b1;
                        end
                        i2cmb_pkg::CMD_WRITE:
                        begin
                            shift_next      = q_item.tx_byte;
                            bit_index_next  = 4'd0;
                            error_flag_next = 1'b0;
                            phase_next      = i2cmb_pkg::PH_W_LOW;
                            scl_next        = 1'b0;
                            tick_count_next = 8'd1;
                            sda_level_next  = q_item.tx_byte[7];
                            sda_drive_next  = !q_item.tx_byte[7];
                        end
                        i2cmb_pkg::CMD_READ:
                        begin
                            shift_next      = 8'd0;
                            bit_index_next  = 4'd0;
                            ack_choice_next = q_item.send_ack;
                            phase_next      = i2cmb_pkg::PH_R_LOW;
                            scl_next        = 1'b0;
                            tick_count_next = 8'd1;
                            sda_level_next  = 1'b1;
                            sda_drive_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                i2cmb_pkg::PH_ST_HI:
                begin
                    if (seg_done)
                    begin
                        phase_next      = i2cmb_pkg::PH_ST_LO;
                        scl_next        = 1'b1;
                        tick_count_next = 8'd1;
                        sda_level_next  = 1'b0;
                        sda_drive_next  = 1'b1;
                    end
                end
                i2cmb_pkg::PH_ST_LO:
                begin
                    if (seg_done)
                    begin
                        scl_next   = 1'b0;
                        phase_next = i2cmb_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                end
                i2cmb_pkg::PH_SP_LO:
                begin
                    if (seg_done)
                    begin
                        phase_next      = i2cmb_pkg::PH_SP_HI;
                        scl_next        = 1'b1;
                        tick_count_next = 8'd1;
                    end
                end
                i2cmb_pkg::PH_SP_HI:
                begin
                    if (seg_done)
                    begin
                        phase_next      = i2cmb_pkg::PH_SP_REL;
                        scl_next        = 1'b1;
                        tick_count_next = 8'd1;
                        sda_level_next  = 1'b1;
                        sda_drive_next  = 1'b0;
                    end
                end
                i2cmb_pkg::PH_SP_REL:
                begin
                    if (seg_done)
                    begin
                        phase_next = i2cmb_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                end
                i2cmb_pkg::PH_W_LOW:
                begin
                    if (seg_done)
                    begin
                        phase_next      = i2cmb_pkg::PH_W_HIGH;
                        scl_next        = 1'b1;
                        tick_count_next = 8'd1;
                    end
                end
                i2cmb_pkg::PH_W_HIGH:
                begin
                    if (seg_done)
                    begin
                        bit_index_next  = bit_inc;
                        shift_next      = shift_left;
                        scl_next        = 1'b0;
                        tick_count_next = 8'd1;
                        if (bit_inc >= i2cmb_pkg::BITS_PER_BYTE)
                        begin
                            phase_next     = i2cmb_pkg::PH_A_REL;
                            sda_level_next = 1'b1;
                            sda_drive_next = 1'b0;
                        end
                        else
                        begin
                            phase_next     = i2cmb_pkg::PH_W_LOW;
                            sda_level_next = shift_left[7];
                            sda_drive_next = !shift_left[7];
                        end
                    end
                end
                i2cmb_pkg::PH_A_REL:
                begin
                    if (seg_done)
                    begin
                        phase_next          = i2cmb_pkg::PH_A_WAIT;
                        scl_next            = 1'b1;
                        tick_count_next     = 8'd1;
                        ack_wait_count_next = 8'd0;
                    end
                end
                i2cmb_pkg::PH_A_WAIT:
                begin
                    if (!q_item.sda_in)
                    begin
                        scl_next   = 1'b0;
                        phase_next = i2cmb_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else if (ack_wait_count_reg >= cfg.ack_timeout_ticks)
                    begin
                        // no ack in time: abort into a stop condition
                        error_flag_next = 1'b1;
                        phase_next      = i2cmb_pkg::PH_SP_LO;
                        scl_next        = 1'b0;
                        tick_count_next = 8'd1;
                        sda_level_next  = 1'b0;
                        sda_drive_next  = 1'b1;
                    end
                    else
                    begin
                        ack_wait_count_next = ack_wait_count_reg + 8'd1;
                    end
                end
                i2cmb_pkg::PH_R_LOW:
                begin
                    if (seg_done)
                    begin
                        phase_next      = i2cmb_pkg::PH_R_HIGH;
                        scl_next        = 1'b1;
                        tick_count_next = 8'd1;
                        shift_next      = {shift_reg[6:0], q_item.sda_in};
                    end
                end
                i2cmb_pkg::PH_R_HIGH:
                begin
                    if (seg_done)
                    begin
                        bit_index_next  = bit_inc;
                        scl_next        = 1'b0;
                        tick_count_next = 8'd1;
                        if (bit_inc >= i2cmb_pkg::BITS_PER_BYTE)
                        begin
                            phase_next     = i2cmb_pkg::PH_K_LOW;
                            sda_level_next = !ack_choice_reg;
                            sda_drive_next = ack_choice_reg;
                        end
                        else
                        begin
                            phase_next = i2cmb_pkg::PH_R_LOW;
                        end
                    end
                end
                i2cmb_pkg::PH_K_LOW:
                begin
                    if (seg_done)
                    begin
                        phase_next      = i2cmb_pkg::PH_K_HIGH;
                        scl_next        = 1'b1;
                        tick_count_next = 8'd1;
                    end
                end
                i2cmb_pkg::PH_K_HIGH:
                begin
                    if (seg_done)
                    begin
                        scl_next     = 1'b0;
                        rx_hold_next = shift_reg;
                        phase_next   = i2cmb_pkg::PH_IDLE;
                        done         = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = i2cmb_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res_item.scl_level = scl_next;
        res_item.sda_drive = sda_drive_next;
        res_item.sda_level = sda_level_next;
        res_item.busy_res  = (phase_next != i2cmb_pkg::PH_IDLE);
        res_item.done_res  = done;
        res_item.rx_byte   = rx_hold_next;
        res_item.ack_error = error_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2cmb_pkg::PH_IDLE;
            tick_count_reg     <= 8'd0;
            bit_index_reg      <= 4'd0;
            shift_reg          <= 8'd0;
            ack_wait_count_reg <= 8'd0;
            ack_choice_reg     <= 1'b0;
            scl_reg            <= 1'b1;
            sda_drive_reg      <= 1'b0;
            sda_level_reg      <= 1'b1;
            error_flag_reg     <= 1'b0;
            rx_hold_reg        <= 8'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            bit_index_reg      <= bit_index_next;
            shift_reg          <= shift_next;
            ack_wait_count_reg <= ack_wait_count_next;
            ack_choice_reg     <= ack_choice_next;
            scl_reg            <= scl_next;
            sda_drive_reg      <= sda_drive_next;
            sda_level_reg      <= sda_level_next;
            error_flag_reg     <= error_flag_next;
            rx_hold_reg        <= rx_hold_next;
        end
    end

    // Result queue: one beat per processed tick
    assign empty      = (res_count_reg == '0);
    assign res_pop_ok = pop && !empty;
    assign result     = res_mem_reg[res_rd_reg];

    always_comb
    begin
        res_count_next = res_count_reg + i2cmb_pkg::Q_CNT_W'(step)
                         - i2cmb_pkg::Q_CNT_W'(res_pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            res_wr_reg    <= res_wr_reg + i2cmb_pkg::Q_PTR_W'(step);
            res_rd_reg    <= res_rd_reg + i2cmb_pkg::Q_PTR_W'(res_pop_ok);
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_mem_reg[res_wr_reg] <= res_item;
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |-> !res_item.busy_res && phase_next == i2cmb_pkg::PH_IDLE)
        else $error("command completed while still busy");

    a_error_from_ack: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(error_flag_reg) |-> $past(phase_reg) == i2cmb_pkg::PH_A_WAIT)
        else $error("ack error raised outside the ack wait");

    a_open_drain: assert property (@(posedge clk) disable iff (!rst_n)
        sda_drive_reg != sda_level_reg)
        else $error("SDA driven high or released low");

endmodule

/* hdl/i2c_master_byte_engine_top.sv */
// Path: a pushed tick is held in the front tick queue, then the back end processes it and writes
// its result into the result queue, from which pop takes it.
// Throughput: one tick per cycle, sustained while pop keeps up; the per-tick bus FSM
// in the back end handles one tick each cycle and the two-beat queues absorb stalls.
// Reset: rst_n is asynchronous, active low; queues empty, FSM idle with SCL high and
// SDA released, configuration registers back to their defaults. No clearing pass.
module i2c_master_byte_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  i2cmb_pkg::tick_t                 tick,
    output logic                             empty,
    input  logic                             pop,
    output i2cmb_pkg::result_t               result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cmb_pkg::ADDR_W-1:0]     paddr,
    input  logic [i2cmb_pkg::DATA_W-1:0]     pwdata,
    output logic [i2cmb_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);

    i2cmb_pkg::cfg_t   cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic              q_valid;
    logic              q_pop;
    i2cmb_pkg::ctick_t q_item;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_low_ticks     <= i2cmb_pkg::RST_BIT_LOW;
            cfg_reg.bit_high_ticks    <= i2cmb_pkg::RST_BIT_HIGH;
            cfg_reg.read_high_ticks   <= i2cmb_pkg::RST_READ_HIGH;
            cfg_reg.start_stop_ticks  <= i2cmb_pkg::RST_START_STOP;
            cfg_reg.ack_timeout_ticks <= i2cmb_pkg::RST_ACK_TIMEOUT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                i2cmb_pkg::REG_BIT_LOW:     cfg_reg.bit_low_ticks     <= pwdata[7:0];
                i2cmb_pkg::REG_BIT_HIGH:    cfg_reg.bit_high_ticks    <= pwdata[7:0];
                i2cmb_pkg::REG_READ_HIGH:   cfg_reg.read_high_ticks   <= pwdata[7:0];
                i2cmb_pkg::REG_START_STOP:  cfg_reg.start_stop_ticks  <= pwdata[7:0];
                i2cmb_pkg::REG_ACK_TIMEOUT: cfg_reg.ack_timeout_ticks <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            i2cmb_pkg::REG_BIT_LOW:     prdata = {24'd0, cfg_reg.bit_low_ticks};
            i2cmb_pkg::REG_BIT_HIGH:    prdata = {24'd0, cfg_reg.bit_high_ticks};
            i2cmb_pkg::REG_READ_HIGH:   prdata = {24'd0, cfg_reg.read_high_ticks};
            i2cmb_pkg::REG_START_STOP:  prdata = {24'd0, cfg_reg.start_stop_ticks};
            i2cmb_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, cfg_reg.ack_timeout_ticks};
            default:                    prdata = '0;
        endcase
    end

    i2cmb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .tick    (tick),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    i2cmb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
